// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/ansplit_pkg.sv =====
// Shared constants and result type for the Annex B unit splitter.
// No dependencies.
package ansplit_pkg;

    // Length counter width: default and largest supported value.
    localparam int LENGTH_BITS_DEFAULT = 24;
    localparam int LEN_MAX_BITS        = 32;

    // Width of the unit length field on the result channel.
    localparam int UNIT_LEN_W = 24;

    // Start code terminator byte and unit type mask.
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [4:0] TYPE_MASK  = 5'h1F;

    // One result transaction.
    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  byte_valid;
        logic                  unit_first;
        logic                  unit_last;
        logic [4:0]            unit_type;
        logic [UNIT_LEN_W-1:0] unit_length;
        logic                  run_last;
    } result_t;

endpackage

// ===== rtl/annexb_nal_unit_splitter_core.sv =====
// Annex B start code parser: splits an image byte stream into unit payload bytes.
// Depends on ansplit_pkg.
//
//  channel | direction | transaction
//  s_      | in        | one stream byte plus image end flag
//  m_      | out       | one payload byte or empty-unit report, with marks
//
// Each byte is handled in the step logic between the input register and the
// result register. Extra steps release each held zero ahead of a nonzero byte
// or at image end, close a unit at image end, and replay the two guard bytes
// once a start is confirmed.
// Reset is synchronous and clears control state only; no memory clearing pass.
// A stalled result channel holds only steps that produce a result.
module annexb_nal_unit_splitter_core #(
    parameter int LENGTH_BITS = ansplit_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_in_byte,
    input  logic                             s_image_end,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_byte_valid,
    output logic                             m_unit_first,
    output logic                             m_unit_last,
    output logic [4:0]                       m_unit_type,
    output logic [ansplit_pkg::UNIT_LEN_W-1:0] m_unit_length,
    output logic                             m_run_last
);
    import ansplit_pkg::*;

    // Parser modes
    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_GUARD  = 2'd1;
    localparam logic [1:0] MODE_UNIT   = 2'd2;

    // Step phases within one input transaction
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_G1    = 2'd1;
    localparam logic [1:0] PH_IN    = 2'd2;

    // Parser state
    logic [1:0]             mode_reg, mode_next;
    logic [1:0]             zcnt_reg, zcnt_next;
    logic [7:0]             hold_byte_reg, hold_byte_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [7:0]             g0_reg, g1_reg;
    logic [1:0]             gcnt_reg, gcnt_next;
    logic                   first_pend_reg, first_pend_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next, len_inc;

    // Input register
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_end_reg;
    logic [1:0]             phase_reg, phase_next;
    logic                   post_reg, post_next;

    // Result register
    logic                   m_valid_reg;
    result_t                out_reg;

    // Step control
    logic                   out_free, step_go, step_emit, step_done, step_rl;
    logic                   act_push, act_end, byte_fin, guard_we;
    logic [7:0]             push_val, unit_c;
    logic                   unit_e;
    logic [LEN_MAX_BITS-1:0] len_wide;
    result_t                res;

    assign out_free = !m_valid_reg || m_ready;
    assign step_go  = in_valid_reg && (!step_emit || out_free);
    assign s_ready  = !in_valid_reg || (step_go && step_done);

    assign len_inc  = (len_reg == '1) ? len_reg : len_reg + LENGTH_BITS'(1);
    assign len_wide = LEN_MAX_BITS'(len_reg);
    assign unit_c   = (phase_reg == PH_G1) ? g1_reg : in_byte_reg;
    assign unit_e   = (phase_reg == PH_G1) ? 1'b0 : in_end_reg;

    // One step of the parser: picks an action, then applies push or close
    always_comb begin
        mode_next       = mode_reg;
        zcnt_next       = zcnt_reg;
        hold_byte_next  = hold_byte_reg;
        hold_valid_next = hold_valid_reg;
        gcnt_next       = gcnt_reg;
        first_pend_next = first_pend_reg;
        len_next        = len_reg;
        phase_next      = phase_reg;
        post_next       = post_reg;
        step_emit       = 1'b0;
        step_done       = 1'b0;
        act_push        = 1'b0;
        act_end         = 1'b0;
        byte_fin        = 1'b0;
        guard_we        = 1'b0;
        push_val        = 8'h00;
        res             = '0;

        if (phase_reg == PH_START && mode_reg == MODE_GUARD && !gcnt_reg[1]) begin
            // collecting the two bytes after a 01
            if (in_end_reg) begin
                mode_next = MODE_SEARCH;
                gcnt_next = 2'd0;
            end else begin
                guard_we  = 1'b1;
                gcnt_next = gcnt_reg + 2'd1;
            end
            step_done = 1'b1;
        end else if (phase_reg == PH_START && mode_reg == MODE_GUARD) begin
            // start confirmed: open unit and take the first guard byte
            mode_next       = MODE_UNIT;
            first_pend_next = 1'b1;
            hold_byte_next  = g0_reg;
            hold_valid_next = (g0_reg != 8'h00);
            zcnt_next       = (g0_reg == 8'h00) ? 2'd1 : 2'd0;
            len_next        = (g0_reg != 8'h00) ? LENGTH_BITS'(1) : '0;
            phase_next      = PH_G1;
        end else if (phase_reg == PH_START && mode_reg != MODE_UNIT) begin
            // searching for a 01
            mode_next = (in_byte_reg == START_BYTE && !in_end_reg) ? MODE_GUARD
                                                                    : MODE_SEARCH;
            gcnt_next = 2'd0;
            step_done = 1'b1;
        end else begin
            // unit byte handling
            if (post_reg) begin
                if (zcnt_reg != 2'd0) begin
                    act_push  = 1'b1;
                    zcnt_next = zcnt_reg - 2'd1;
                end else begin
                    act_end   = 1'b1;
                    mode_next = MODE_SEARCH;
                    step_done = 1'b1;
                end
            end else if (unit_c == START_BYTE && zcnt_reg[1]) begin
                act_end   = 1'b1;
                mode_next = unit_e ? MODE_SEARCH : MODE_GUARD;
                gcnt_next = 2'd0;
                step_done = 1'b1;
            end else if (unit_c == 8'h00) begin
                if (zcnt_reg != 2'd3) begin
                    zcnt_next = zcnt_reg + 2'd1;
                end else begin
                    act_push = 1'b1;
                end
                byte_fin = 1'b1;
            end else if (zcnt_reg != 2'd0) begin
                // release one held zero ahead of the byte
                act_push  = 1'b1;
                zcnt_next = zcnt_reg - 2'd1;
            end else begin
                act_push = 1'b1;
                push_val = unit_c;
                byte_fin = 1'b1;
            end

            if (byte_fin) begin
                if (unit_e) begin
                    post_next = 1'b1;
                end else if (phase_reg == PH_G1) begin
                    phase_next = PH_IN;
                end else begin
                    step_done = 1'b1;
                end
            end
        end

        // push through the one-byte delay
        if (act_push) begin
            if (hold_valid_reg) begin
                step_emit       = 1'b1;
                res.out_byte    = hold_byte_reg;
                res.byte_valid  = 1'b1;
                res.unit_first  = first_pend_reg;
                first_pend_next = 1'b0;
            end
            hold_byte_next  = push_val;
            hold_valid_next = 1'b1;
            len_next        = len_inc;
        end

        // close the unit
        if (act_end) begin
            step_emit       = 1'b1;
            res.out_byte    = hold_valid_reg ? hold_byte_reg : 8'h00;
            res.byte_valid  = hold_valid_reg;
            res.unit_first  = hold_valid_reg ? first_pend_reg : 1'b1;
            res.unit_last   = 1'b1;
            res.unit_length = len_wide[UNIT_LEN_W-1:0];
            hold_valid_next = 1'b0;
            zcnt_next       = 2'd0;
            first_pend_next = 1'b0;
            len_next        = '0;
        end

        res.unit_type = (res.unit_first && res.byte_valid) ? (res.out_byte[4:0] & TYPE_MASK)
                                                           : 5'd0;

        // last result of the transaction: nothing after this step produces one
        step_rl = step_done ||
                  (phase_reg == PH_G1 && phase_next == PH_IN && in_byte_reg == 8'h00 &&
                   zcnt_next != 2'd3 && !in_end_reg);
        res.run_last = step_rl;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_SEARCH;
            zcnt_reg       <= 2'd0;
            hold_valid_reg <= 1'b0;
            gcnt_reg       <= 2'd0;
            first_pend_reg <= 1'b0;
            len_reg        <= '0;
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_START;
            post_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (step_go) begin
                mode_reg       <= mode_next;
                zcnt_reg       <= zcnt_next;
                hold_valid_reg <= hold_valid_next;
                gcnt_reg       <= gcnt_next;
                first_pend_reg <= first_pend_next;
                len_reg        <= len_next;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                phase_reg    <= PH_START;
                post_reg     <= 1'b0;
            end else if (step_go) begin
                if (step_done) begin
                    in_valid_reg <= 1'b0;
                end
                phase_reg <= phase_next;
                post_reg  <= post_next;
            end
            if (step_go && step_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (step_go) begin
            hold_byte_reg <= hold_byte_next;
        end
        if (step_go && guard_we) begin
            if (!gcnt_reg[0]) begin
                g0_reg <= in_byte_reg;
            end else begin
                g1_reg <= in_byte_reg;
            end
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_image_end;
        end
        if (step_go && step_emit) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_reg.out_byte;
    assign m_byte_valid  = out_reg.byte_valid;
    assign m_unit_first  = out_reg.unit_first;
    assign m_unit_last   = out_reg.unit_last;
    assign m_unit_type   = out_reg.unit_type;
    assign m_unit_length = out_reg.unit_length;
    assign m_run_last    = out_reg.run_last;

endmodule

// ===== rtl/ansplit_checker.sv =====
// Port-level checks on the result channel of the unit splitter, plus bind.
// Depends on ansplit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ansplit_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [7:0]                        m_out_byte,
    input logic                              m_byte_valid,
    input logic                              m_unit_first,
    input logic                              m_unit_last,
    input logic [4:0]                        m_unit_type,
    input logic [ansplit_pkg::UNIT_LEN_W-1:0] m_unit_length,
    input logic                              m_run_last
);
    import ansplit_pkg::*;

    // Handshake: stalled item stays offered; byte, length and marks hold
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready, $stable(m_out_byte) && $stable(m_unit_length) && $stable(m_unit_first) && $stable(m_unit_last) && $stable(m_run_last))

    // Type only on the first payload byte, length only on the closing item
    `ASSERT_IMPL(a_type_first, aclk, aresetn, m_valid && !(m_unit_first && m_byte_valid), m_unit_type == 5'd0)
    `ASSERT_IMPL(a_len_last, aclk, aresetn, m_valid && !m_unit_last, m_unit_length == '0)

    // Empty-unit report is a complete unit on its own
    `ASSERT_IMPL(a_empty_unit, aclk, aresetn, m_valid && !m_byte_valid, m_unit_first && m_unit_last && m_out_byte == 8'h00 && m_unit_length == '0)

endmodule

bind annexb_nal_unit_splitter_core ansplit_checker u_ansplit_checker (.*);
